[hdl/tpsf_pkg.sv]
package tpsf_pkg;

   // Magnitude of a coordinate difference; coordinates are at most 32 bits wide.
   localparam int DW = 33;
   // Square of one difference and the sum of three squares.
   localparam int SQW = 2 * DW;
   localparam int SUMW = SQW + 2;
   // Root of the sum of squares.
   localparam int MW = DW;
   // Register width of rest length and stiffness.
   localparam int RW = 31;
   // Length error, magnitude of the force and the unit vector component.
   localparam int LW = (MW > RW) ? MW : RW;
   localparam int MAGW = LW + RW - 16;
   localparam int UW = 17;
   localparam int VW = MAGW + UW - 16;
   localparam int OW = 32;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      REG_REST_LENGTH     = 1'b0,
      REG_SPRING_CONSTANT = 1'b1
   } reg_index_type;

   // Configuration values seen by the force stages.
   typedef struct packed {
      logic [RW-1:0] rest_length;
      logic [RW-1:0] spring_constant;
   } cfg_type;

   // One classified item passed from the distance part to the force part.
   typedef struct packed {
      logic [2:0][DW-1:0] dabs;
      logic [2:0]         dneg;
      logic [MW-1:0]      root;
      logic               zero;
   } item_type;

endpackage

[hdl/tpsf_front.sv]
module tpsf_front #(
   parameter int EW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_self_x,
   input  logic [31:0]             req_self_y,
   input  logic [31:0]             req_self_z,
   input  logic [31:0]             req_other_x,
   input  logic [31:0]             req_other_y,
   input  logic [31:0]             req_other_z,
   output logic                    push,
   output tpsf_pkg::item_type      push_item,
   input  logic                    q_full
);

   localparam int DW = tpsf_pkg::DW;
   localparam int SQW = tpsf_pkg::SQW;
   localparam int SUMW = tpsf_pkg::SUMW;
   localparam int MW = tpsf_pkg::MW;

   logic                     en;
   logic signed [DW-1:0]     self_s [3];
   logic signed [DW-1:0]     other_s [3];
   logic signed [DW-1:0]     diff [3];
   logic [2:0][DW-1:0]       dabs_in;
   logic [2:0]               dneg_in;

   logic                     d_vld_ff;
   logic                     q_vld_ff;
   logic [MW:0]              s_vld_ff;
   logic [2:0][DW-1:0]       dabs_d_ff;
   logic [2:0]               dneg_d_ff;
   logic [2:0][DW-1:0]       dabs_q_ff;
   logic [2:0]               dneg_q_ff;
   logic [SQW-1:0]           sq_ff [3];
   logic [SUMW-1:0]          rem_ff [0:MW];
   logic [MW-1:0]            root_ff [0:MW];
   logic [2:0][DW-1:0]       dab_s_ff [0:MW];
   logic [2:0]               dneg_s_ff [0:MW];

   // The whole distance pipeline holds while its finished item cannot enter the queue.
   assign en = !(s_vld_ff[MW] && q_full);
   assign req_stall = !en;

   // Only the low EW bits of each coordinate count, sign-extended.
   assign self_s[0] = DW'($signed(req_self_x[EW-1:0]));
   assign self_s[1] = DW'($signed(req_self_y[EW-1:0]));
   assign self_s[2] = DW'($signed(req_self_z[EW-1:0]));
   assign other_s[0] = DW'($signed(req_other_x[EW-1:0]));
   assign other_s[1] = DW'($signed(req_other_y[EW-1:0]));
   assign other_s[2] = DW'($signed(req_other_z[EW-1:0]));

   // Difference per axis, split into magnitude and sign.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = self_s[i] - other_s[i];
         dneg_in[i] = diff[i][DW-1];
         dabs_in[i] = diff[i][DW-1] ? DW'(-diff[i]) : DW'(diff[i]);
      end
   end

   // Valid bits of the distance pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         q_vld_ff <= 1'b0;
         s_vld_ff <= '0;
      end else if (en) begin
         d_vld_ff <= req_valid;
         q_vld_ff <= d_vld_ff;
         s_vld_ff <= {s_vld_ff[MW-1:0], q_vld_ff};
      end
   end

   // Difference, square and sum stages.
   always_ff @(posedge clock) begin
      if (en) begin
         dabs_d_ff <= dabs_in;
         dneg_d_ff <= dneg_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQW'(dabs_d_ff[i]) * SQW'(dabs_d_ff[i]);
         end
         dabs_q_ff <= dabs_d_ff;
         dneg_q_ff <= dneg_d_ff;
         rem_ff[0] <= SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
         root_ff[0] <= '0;
         dab_s_ff[0] <= dabs_q_ff;
         dneg_s_ff[0] <= dneg_q_ff;
      end
   end

   // Square root, one result bit per stage, keeping the remainder S - root^2.
   for (genvar k = 0; k < MW; k++) begin : g_sqrt
      localparam int B = MW - 1 - k;
      logic [SUMW:0]   trial;
      logic [SUMW-1:0] rem_in;
      logic [MW-1:0]   root_in;

      always_comb begin
         trial = ((SUMW + 1)'(root_ff[k]) << (B + 1)) | ((SUMW + 1)'(1) << (2 * B));
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_in = rem_ff[k] - trial[SUMW-1:0];
            root_in = root_ff[k] | (MW'(1) << B);
         end else begin
            rem_in = rem_ff[k];
            root_in = root_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            root_ff[k+1] <= root_in;
            dab_s_ff[k+1] <= dab_s_ff[k];
            dneg_s_ff[k+1] <= dneg_s_ff[k];
         end
      end
   end

   // Finished item, classified by whether the two ends coincide.
   assign push = s_vld_ff[MW] && !q_full;
   assign push_item.dabs = dab_s_ff[MW];
   assign push_item.dneg = dneg_s_ff[MW];
   assign push_item.root = root_ff[MW];
   assign push_item.zero = (root_ff[MW] == '0);

endmodule

[hdl/tpsf_queue.sv]
module tpsf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tpsf_pkg::item_type   push_item,
   output logic                 full,
   input  logic                 pop,
   output tpsf_pkg::item_type   pop_item,
   output logic                 empty
);

   localparam int DEPTH = 4;
   localparam int AW = $clog2(DEPTH);

   tpsf_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff;
   logic [AW-1:0]      rd_ptr_ff;
   logic [AW:0]        count_ff;

   assign full = (count_ff == (AW + 1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hdl/tpsf_back.sv]
module tpsf_back #(
   parameter int EW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  tpsf_pkg::item_type   q_item,
   output logic                 pop,
   input  tpsf_pkg::cfg_type    cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [31:0]          rsp_force_x,
   output logic [31:0]          rsp_force_y,
   output logic [31:0]          rsp_force_z
);

   localparam int MW = tpsf_pkg::MW;
   localparam int RW = tpsf_pkg::RW;
   localparam int LW = tpsf_pkg::LW;
   localparam int MAGW = tpsf_pkg::MAGW;
   localparam int UW = tpsf_pkg::UW;
   localparam int VW = tpsf_pkg::VW;
   localparam int OW = tpsf_pkg::OW;

   logic                 en;
   logic [LW-1:0]        root_ext;
   logic [LW-1:0]        rest_ext;
   logic [LW+RW-1:0]     emul;
   logic [VW-1:0]        lim_pos;
   logic [VW-1:0]        lim_neg;
   logic [MAGW+UW-1:0]   vmul [3];
   logic [OW-1:0]        force_in [3];

   logic [UW:0]          vld_ff;
   logic [LW-1:0]        e_ff;
   logic [MW-1:0]        rem_ff [0:UW][3];
   logic [UW-1:0]        q_ff [0:UW][3];
   logic [MW-1:0]        m_ff [0:UW-1];
   logic [2:0]           dneg_ff [0:UW];
   logic                 zero_ff [0:UW];
   logic [MAGW-1:0]      mag_ff [1:UW];
   logic                 vld_p_ff;
   logic [VW-1:0]        v_ff [3];
   logic [2:0]           dneg_p_ff;
   logic                 zero_p_ff;
   logic                 rsp_valid_ff;
   logic [OW-1:0]        force_ff [3];

   // The force pipeline holds while the output register is full and stalled.
   assign en = !(rsp_valid_ff && rsp_stall);
   assign pop = en && !q_empty;

   // Valid bits of the force pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         vld_p_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[UW-1:0], !q_empty};
         vld_p_ff <= vld_ff[UW];
         rsp_valid_ff <= vld_p_ff;
      end
   end

   // Length error against the rest length.
   assign root_ext = LW'(q_item.root);
   assign rest_ext = LW'(cfg.rest_length);

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= (root_ext >= rest_ext) ? root_ext - rest_ext : rest_ext - root_ext;
         m_ff[0] <= q_item.root;
         dneg_ff[0] <= q_item.dneg;
         zero_ff[0] <= q_item.zero;
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= q_item.dabs[i];
            q_ff[0][i] <= '0;
         end
      end
   end

   assign emul = (LW + RW)'(e_ff) * (LW + RW)'(cfg.spring_constant);

   // Division of each magnitude, shifted up 16 bits, by the root: one quotient bit a stage.
   for (genvar j = 0; j < UW; j++) begin : g_div
      localparam int QB = UW - 1 - j;

      for (genvar i = 0; i < 3; i++) begin : g_lane
         logic [MW:0]   rsh;
         logic          fit;
         logic [MW:0]   diff;
         logic [MW-1:0] rem_in;
         logic [UW-1:0] q_in;

         always_comb begin
            rsh = (j == 0) ? {1'b0, rem_ff[j][i]} : {rem_ff[j][i], 1'b0};
            fit = (rsh >= {1'b0, m_ff[j]});
            diff = rsh - {1'b0, m_ff[j]};
            rem_in = fit ? diff[MW-1:0] : rsh[MW-1:0];
            q_in = q_ff[j][i] | (UW'(fit) << QB);
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j+1][i] <= rem_in;
               q_ff[j+1][i] <= q_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dneg_ff[j+1] <= dneg_ff[j];
            zero_ff[j+1] <= zero_ff[j];
         end
      end

      if (j + 1 < UW) begin : g_m
         always_ff @(posedge clock) begin
            if (en) begin
               m_ff[j+1] <= m_ff[j];
            end
         end
      end

      // The force magnitude is formed in the first stage and travels alongside.
      if (j == 0) begin : g_mag_first
         always_ff @(posedge clock) begin
            if (en) begin
               mag_ff[1] <= emul[LW+RW-1:16];
            end
         end
      end else begin : g_mag_carry
         always_ff @(posedge clock) begin
            if (en) begin
               mag_ff[j+1] <= mag_ff[j];
            end
         end
      end
   end

   // Magnitude times unit component.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vmul[i] = (MAGW + UW)'(mag_ff[UW]) * (MAGW + UW)'(q_ff[UW][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= vmul[i][MAGW+UW-1:16];
         end
         dneg_p_ff <= dneg_ff[UW];
         zero_p_ff <= zero_ff[UW];
      end
   end

   // The force points against d; saturate to the coordinate width.
   assign lim_pos = (VW'(1) << (EW - 1)) - VW'(1);
   assign lim_neg = VW'(1) << (EW - 1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [VW-1:0] vs;
         logic [VW-1:0] vneg;
         vs = '0;
         vneg = '0;
         if (zero_p_ff) begin
            force_in[i] = '0;
         end else if (dneg_p_ff[i]) begin
            vs = (v_ff[i] > lim_pos) ? lim_pos : v_ff[i];
            force_in[i] = vs[OW-1:0];
         end else begin
            vs = (v_ff[i] > lim_neg) ? lim_neg : v_ff[i];
            vneg = '0 - vs;
            force_in[i] = vneg[OW-1:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            force_ff[i] <= force_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_force_x = force_ff[0];
   assign rsp_force_y = force_ff[1];
   assign rsp_force_z = force_ff[2];

endmodule

[hdl/two_point_spring_force.sv]
// Hooke spring force on one end of a two-point spring, Q16.16 fixed point.
// Input channel (req_): one item carries the positions of the particle and of
// the spring's other end; it is taken at a clock edge with req_valid high and
// req_stall low. Result channel (rsp_): one item with the three force
// components, saturated, taken with rsp_valid high and rsp_stall low.
// The csr_ port writes rest length (index 0) and stiffness (index 1); the user
// must write them only while the block is idle; the block does not enforce this.
// Throughput is one item per clock while neither channel stalls. Each item goes
// through a 36-stage distance pipeline (difference, square, sum and a
// one-bit-per-stage square root), a 4-entry queue and a 20-stage force pipeline
// (length error, a one-bit-per-stage divider that forms the unit vector,
// multiply, saturate and output register).
// When the receiver stalls, the force pipeline holds; the distance pipeline
// keeps accepting items until the queue is full, then raises req_stall.
// Synchronous reset empties both pipelines and the queue and sets rest length
// and stiffness to 1.0.
module two_point_spring_force #(
   parameter int COORD_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [31:0]  req_self_x,
   input  logic [31:0]  req_self_y,
   input  logic [31:0]  req_self_z,
   input  logic [31:0]  req_other_x,
   input  logic [31:0]  req_other_y,
   input  logic [31:0]  req_other_z,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [31:0]  rsp_force_x,
   output logic [31:0]  rsp_force_y,
   output logic [31:0]  rsp_force_z,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [30:0]  csr_data
);

   localparam int EW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

   tpsf_pkg::cfg_type  cfg_ff;
   tpsf_pkg::item_type push_item;
   tpsf_pkg::item_type pop_item;
   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rest_length <= tpsf_pkg::RW'(65536);
         cfg_ff.spring_constant <= tpsf_pkg::RW'(65536);
      end else if (csr_write) begin
         unique case (tpsf_pkg::reg_index_type'(csr_index))
            tpsf_pkg::REG_REST_LENGTH:     cfg_ff.rest_length <= csr_data;
            tpsf_pkg::REG_SPRING_CONSTANT: cfg_ff.spring_constant <= csr_data;
            default: ;
         endcase
      end
   end

   tpsf_front #(.EW(EW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_self_x  (req_self_x),
      .req_self_y  (req_self_y),
      .req_self_z  (req_self_z),
      .req_other_x (req_other_x),
      .req_other_y (req_other_y),
      .req_other_z (req_other_z),
      .push        (push),
      .push_item   (push_item),
      .q_full      (q_full)
   );

   tpsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   tpsf_back #(.EW(EW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_item      (pop_item),
      .pop         (pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_force_x (rsp_force_x),
      .rsp_force_y (rsp_force_y),
      .rsp_force_z (rsp_force_z)
   );

endmodule
